// File: rtl/fna_pkg.sv
// ----------------------------------------------------------------------------
// fna_pkg
// Shared types and constants of the four-neighbor average stencil.
// ----------------------------------------------------------------------------
package fna_pkg;

    // Frame limits and sample width
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 16;

    // Derived widths
    localparam int SUM_BITS       = PIXEL_BITS + 2;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 1;
    localparam int MAX_DIM        = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_NEED       = $clog2(MAX_DIM + 1);
    localparam int DIM_BITS       = (CFG_BITS > DIM_NEED) ? CFG_BITS : DIM_NEED;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    // Reset value of both size registers
    localparam logic [CFG_BITS-1:0] SIZE_RESET = CFG_BITS'(1024);

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    // Input beat
    typedef struct packed {
        opcode_t               opcode;
        logic [PIXEL_BITS-1:0] pixel;
    } fna_in_t;

    // Result beat
    typedef struct packed {
        logic [SUM_BITS-1:0] average_quarters;
        logic                frame_end;
    } fna_out_t;

    // Per-item control handed from the sequencer to the datapath
    typedef struct packed {
        logic [COL_BITS-1:0]   col;
        logic [PIXEL_BITS-1:0] px;
        logic                  flush;
        logic                  emit;
        logic                  wr;
        logic                  up_en;
        logic                  left_en;
        logic                  right_en;
        logic                  frame_end;
        logic                  live;
    } fna_issue_t;

endpackage

// File: rtl/fna_ram.sv
// ----------------------------------------------------------------------------
// fna_ram
// Row store: one write port, two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
module fna_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: rtl/fna_ctrl.sv
// ----------------------------------------------------------------------------
// fna_ctrl
// Size registers, raster position counters and per-item decisions.
// ----------------------------------------------------------------------------
module fna_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  fna_pkg::fna_in_t                    in_beat,
    input  logic                                cfg_we,
    input  logic [fna_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fna_pkg::CFG_BITS-1:0]        cfg_data,
    output fna_pkg::fna_issue_t                 issue
);
    import fna_pkg::*;

    logic [CFG_BITS-1:0] frame_width_reg;
    logic [CFG_BITS-1:0] frame_height_reg;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] flush_reg, flush_next;
    logic                loaded_reg, loaded_next;

    logic [DIM_BITS-1:0] fw_ext, fh_ext, w_eff, h_eff;
    logic [DIM_BITS-1:0] c_ext, r_ext, fc_ext;
    logic [DIM_BITS-1:0] c_pos, r_pos, fc_pos;
    logic [DIM_BITS-1:0] c_inc, r_inc, fc_inc;
    logic                last_col, last_row, last_fcol;

    // Effective frame size: zero acts as one, too large acts as the maximum
    always_comb begin
        fw_ext = DIM_BITS'(frame_width_reg);
        fh_ext = DIM_BITS'(frame_height_reg);
        if (fw_ext == '0) begin
            w_eff = DIM_BITS'(1);
        end else if (fw_ext > DIM_BITS'(MAX_WIDTH)) begin
            w_eff = DIM_BITS'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        if (fh_ext == '0) begin
            h_eff = DIM_BITS'(1);
        end else if (fh_ext > DIM_BITS'(MAX_HEIGHT)) begin
            h_eff = DIM_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = fh_ext;
        end
    end

    // Positions clamped to the current frame size
    always_comb begin
        c_ext  = DIM_BITS'(col_reg);
        r_ext  = DIM_BITS'(row_reg);
        fc_ext = DIM_BITS'(flush_reg);
        c_pos  = (c_ext >= w_eff)  ? w_eff - DIM_BITS'(1) : c_ext;
        r_pos  = (r_ext >= h_eff)  ? h_eff - DIM_BITS'(1) : r_ext;
        fc_pos = (fc_ext >= w_eff) ? w_eff - DIM_BITS'(1) : fc_ext;
        c_inc  = c_pos + DIM_BITS'(1);
        r_inc  = r_pos + DIM_BITS'(1);
        fc_inc = fc_pos + DIM_BITS'(1);
        last_col  = (c_inc >= w_eff);
        last_row  = (r_inc >= h_eff);
        last_fcol = (fc_inc >= w_eff);
    end

    // Item decisions for the datapath
    always_comb begin
        issue.px = in_beat.pixel;
        case (in_beat.opcode)
            OP_PIXEL: begin
                issue.col       = c_pos[COL_BITS-1:0];
                issue.flush     = 1'b0;
                issue.emit      = !loaded_reg && (r_pos >= DIM_BITS'(1));
                issue.wr        = !loaded_reg;
                issue.up_en     = (r_pos >= DIM_BITS'(2));
                issue.left_en   = (c_pos != '0);
                issue.right_en  = !last_col;
                issue.frame_end = 1'b0;
            end
            OP_FLUSH: begin
                issue.col       = fc_pos[COL_BITS-1:0];
                issue.flush     = 1'b1;
                issue.emit      = loaded_reg;
                issue.wr        = 1'b0;
                issue.up_en     = (h_eff >= DIM_BITS'(2));
                issue.left_en   = (fc_pos != '0);
                issue.right_en  = !last_fcol;
                issue.frame_end = last_fcol;
            end
            default: begin
                issue.col       = '0;
                issue.flush     = 1'b0;
                issue.emit      = 1'b0;
                issue.wr        = 1'b0;
                issue.up_en     = 1'b0;
                issue.left_en   = 1'b0;
                issue.right_en  = 1'b0;
                issue.frame_end = 1'b0;
            end
        endcase
        issue.live = issue.emit || issue.wr;
    end

    // Counter advance on an accepted beat
    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        flush_next  = flush_reg;
        loaded_next = loaded_reg;
        if (accept) begin
            case (in_beat.opcode)
                OP_PIXEL: begin
                    if (!loaded_reg) begin
                        if (last_col) begin
                            col_next = '0;
                            if (last_row) begin
                                loaded_next = 1'b1;
                                row_next    = '0;
                                flush_next  = '0;
                            end else begin
                                row_next = r_inc[ROW_BITS-1:0];
                            end
                        end else begin
                            col_next = c_inc[COL_BITS-1:0];
                        end
                    end
                end
                OP_FLUSH: begin
                    if (loaded_reg) begin
                        if (last_fcol) begin
                            loaded_next = 1'b0;
                            flush_next  = '0;
                            col_next    = '0;
                            row_next    = '0;
                        end else begin
                            flush_next = fc_inc[COL_BITS-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= SIZE_RESET;
            frame_height_reg <= SIZE_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            flush_reg        <= '0;
            loaded_reg       <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            flush_reg  <= flush_next;
            loaded_reg <= loaded_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/four_neighbour_average.sv
// ----------------------------------------------------------------------------
// four_neighbour_average
// Four-neighbor sum of a raster pixel stream in quarter-pixel units.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Beat
//  input     s_valid / s_ready / s_data     opcode, pixel
//  result    m_valid / m_ready / m_data     average_quarters, frame_end
//  config    cfg_we / cfg_index / cfg_data  frame_width, frame_height
//
//  One beat per cycle while s_ready is high. A beat passes the read stage
//  (both row stores read at two addresses) and then the sum/write-back
//  stage, whose result is registered in the result register.
//  Writes of the previous beat to the address being read are forwarded.
//  s_ready drops only while the result register holds a beat that is not
//  taken and stage 1 holds another result. Row stores need no clearing.
// ----------------------------------------------------------------------------
module four_neighbour_average (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fna_pkg::fna_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fna_pkg::fna_out_t                   m_data,
    input  logic                                cfg_we,
    input  logic [fna_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fna_pkg::CFG_BITS-1:0]        cfg_data
);
    import fna_pkg::*;

    fna_issue_t            issue;
    logic                  accept;
    logic                  advance;
    logic                  wr_fire;

    fna_issue_t            st1_reg;
    logic                  st1_valid_reg, st1_valid_next;

    logic [COL_BITS-1:0]   prev_ra, prev_rb, rbp_ra, rbp_rb;
    logic [PIXEL_BITS-1:0] prev_rd_a, prev_rd_b, rbp_rd_a, rbp_rd_b;
    logic [PIXEL_BITS-1:0] prev_a_val, prev_b_val, rbp_a_val, rbp_b_val;

    logic                  hit_pa_reg, hit_pb_reg, hit_ra_reg, hit_rb_reg;
    logic [PIXEL_BITS-1:0] fwd_prev_reg, fwd_rbp_reg;

    logic [SUM_BITS-1:0]   up_term, left_term, right_term, down_term, sum;

    logic                  m_valid_reg, m_valid_next;
    fna_out_t              m_data_reg;

    assign accept  = s_valid && s_ready;
    assign advance = st1_valid_reg && (!st1_reg.emit || !m_valid_reg || m_ready);
    assign s_ready = !st1_valid_reg || advance;
    assign wr_fire = advance && st1_reg.wr;

    fna_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_beat   (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .issue     (issue)
    );

    // Read addresses: flush reads the last row on both sides
    always_comb begin
        prev_ra = issue.flush ? issue.col - COL_BITS'(1) : issue.col;
        prev_rb = issue.col + COL_BITS'(1);
        rbp_ra  = issue.col;
        rbp_rb  = issue.col - COL_BITS'(1);
    end

    // Most recent row
    fna_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIXEL_BITS)
    ) u_prev_row (
        .clk     (aclk),
        .we      (wr_fire),
        .waddr   (st1_reg.col),
        .wdata   (st1_reg.px),
        .re      (accept),
        .raddr_a (prev_ra),
        .raddr_b (prev_rb),
        .rdata_a (prev_rd_a),
        .rdata_b (prev_rd_b)
    );

    // Row before it
    fna_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIXEL_BITS)
    ) u_rbp_row (
        .clk     (aclk),
        .we      (wr_fire),
        .waddr   (st1_reg.col),
        .wdata   (prev_a_val),
        .re      (accept),
        .raddr_a (rbp_ra),
        .raddr_b (rbp_rb),
        .rdata_a (rbp_rd_a),
        .rdata_b (rbp_rd_b)
    );

    // Forwarding of the write that lands in the read cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            hit_pa_reg   <= wr_fire && (st1_reg.col == prev_ra);
            hit_pb_reg   <= wr_fire && (st1_reg.col == prev_rb);
            hit_ra_reg   <= wr_fire && (st1_reg.col == rbp_ra);
            hit_rb_reg   <= wr_fire && (st1_reg.col == rbp_rb);
            fwd_prev_reg <= st1_reg.px;
            fwd_rbp_reg  <= prev_a_val;
        end
    end

    assign prev_a_val = hit_pa_reg ? fwd_prev_reg : prev_rd_a;
    assign prev_b_val = hit_pb_reg ? fwd_prev_reg : prev_rd_b;
    assign rbp_a_val  = hit_ra_reg ? fwd_rbp_reg  : rbp_rd_a;
    assign rbp_b_val  = hit_rb_reg ? fwd_rbp_reg  : rbp_rd_b;

    // Stage 1 control
    always_comb begin
        if (accept) begin
            st1_valid_next = issue.live;
        end else if (advance) begin
            st1_valid_next = 1'b0;
        end else begin
            st1_valid_next = st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= issue;
        end
    end

    // Neighbor sum; left comes from the last row on flush, else the row
    // store entry just written for this row's previous column
    always_comb begin
        up_term    = st1_reg.up_en ? SUM_BITS'(rbp_a_val) : '0;
        right_term = st1_reg.right_en ? SUM_BITS'(prev_b_val) : '0;
        down_term  = st1_reg.flush ? '0 : SUM_BITS'(st1_reg.px);
        if (!st1_reg.left_en) begin
            left_term = '0;
        end else if (st1_reg.flush) begin
            left_term = SUM_BITS'(prev_a_val);
        end else begin
            left_term = SUM_BITS'(rbp_b_val);
        end
        sum = up_term + left_term + right_term + down_term;
    end

    // Result register
    always_comb begin
        if (advance && st1_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && st1_reg.emit) begin
            m_data_reg.average_quarters <= sum;
            m_data_reg.frame_end        <= st1_reg.frame_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/fna_checker.sv
// ----------------------------------------------------------------------------
// fna_checker
// Port-level checks of the four-neighbor average stencil.
// ----------------------------------------------------------------------------
module fna_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              m_valid,
    input  logic              m_ready,
    input  fna_pkg::fna_out_t m_data
);
    import fna_pkg::*;

    // Held result beat stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A fresh result needs an accepted input beat that passed stage 1 and the result register without a stall
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input beat");

    // A consumer that takes results never stalls the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind four_neighbour_average fna_checker u_fna_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
